// ===== rtl/ptdt_pkg.sv =====
// Shared types and constants for the periodic task dispatch table.
package ptdt_pkg;
    localparam int TableSlots = 16;
    localparam int SlotBits = $clog2(TableSlots);
    localparam int CountBits = $clog2(TableSlots + 1);
    localparam int MaxResults = 16;

    localparam logic [2:0] OP_REGISTER = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_SUSPEND = 3'd2;
    localparam logic [2:0] OP_WAKE = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;
    localparam logic [2:0] OP_TICK = 3'd5;
    localparam logic [2:0] OP_PROCESS = 3'd6;
    localparam logic [2:0] OP_SPARE = 3'd7;

    localparam logic [1:0] MODE_ONESHOT = 2'd0;
    localparam logic [1:0] MODE_REPEAT = 2'd1;
    localparam logic [1:0] MODE_FOREVER = 2'd2;
    localparam logic [1:0] MODE_VERDICT = 2'd3;

    localparam logic [1:0] KIND_ACK = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_NONE_DUE = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    localparam logic [1:0] TS_ABSENT = 2'd0;
    localparam logic [1:0] TS_RUNNING = 2'd1;
    localparam logic [1:0] TS_SUSPENDED = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  task_id;
        logic [1:0]  run_mode;
        logic [15:0] repeat_count;
        logic [31:0] period_ticks;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic       refused;
        logic [7:0] task_out;
        logic [1:0] task_state;
        logic       wants_verdict;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  task_id;
        logic [1:0]  mode;
        logic [15:0] remaining;
        logic [31:0] period;
        logic [31:0] elapsed;
        logic        due;
    } t_slot;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND,
        ST_DECIDE,
        ST_SHIFT,
        ST_PLACE,
        ST_TICK,
        ST_PROC,
        ST_EMIT
    } t_state;
endpackage

// ===== rtl/ptdt_slot_table.sv =====
// Slot table registers with one read port and one write port.
module ptdt_slot_table (
    input  logic                                i_clk,
    input  logic [ptdt_pkg::SlotBits-1:0]       i_rd_idx,
    output ptdt_pkg::t_slot                     o_rd,
    input  logic                                i_wr_en,
    input  logic [ptdt_pkg::SlotBits-1:0]       i_wr_idx,
    input  ptdt_pkg::t_slot                     i_wr
);
    import ptdt_pkg::*;

    t_slot r_slot [TableSlots];

    assign o_rd = r_slot[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_slot[i_wr_idx] <= i_wr;
        end
    end
endmodule

// ===== rtl/periodic_task_dispatch_table.sv =====
// Top level of the periodic task dispatch table: sequencer around the slot table.
//
// Usage: raise start with an item while busy is low; the item is taken at that edge and
// busy stays high until the block is done with it. Every operation walks the slot table one
// slot per cycle through a single read and write port, but a process scan pauses while a
// spent task is moved. A search walks up to the match (or to the end when there is none),
// a decision state follows, and an entry is moved by a ripple of single-slot copies in the
// shift state before it is placed. Tick visits every running task. Process visits the
// running tasks in order, stopping once MaxResults tasks have been dispatched; each removal
// of a spent task also shifts the entries behind it down. Results appear on o_result for
// one cycle each, flagged by o_strobe, with last set on the final result of the item, which
// is presented in the first cycle after busy falls; earlier dispatches of a process leave
// while busy is still high. The receiver cannot stall them,
// so it must always take them.
module periodic_task_dispatch_table (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  ptdt_pkg::t_in_item    i_item,
    output logic                  busy,
    output logic                  o_strobe,
    output ptdt_pkg::t_out_item   o_result
);
    import ptdt_pkg::*;

    t_state r_state, n_state;
    t_in_item r_item;
    logic [CountBits-1:0] r_run, r_susp;
    logic [CountBits-1:0] r_idx, r_found, r_dst, r_src;
    logic r_hit;
    logic [CountBits-1:0] r_nres;
    t_slot r_hold;
    t_out_item r_pend, n_pend;
    t_out_item r_res, n_res;
    logic r_strobe, n_strobe;

    logic [SlotBits-1:0] rd_idx, wr_idx;
    t_slot rd_slot, wr_slot;
    logic wr_en;
    logic [CountBits-1:0] total;
    logic [32:0] inc;
    logic full, find_hit, move_needed, one_shot;
    logic proc_live, proc_drop, proc_fire;
    t_slot reg_slot;

    ptdt_slot_table u_table (
        .i_clk    (i_clk),
        .i_rd_idx (rd_idx),
        .o_rd     (rd_slot),
        .i_wr_en  (wr_en),
        .i_wr_idx (wr_idx),
        .i_wr     (wr_slot)
    );

    assign total = r_run + r_susp;
    assign busy = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;
    assign inc = {1'b0, rd_slot.elapsed} + 33'd1;
    assign full = (total >= CountBits'(TableSlots));
    assign one_shot = (r_item.run_mode == MODE_ONESHOT);
    assign find_hit = (r_idx < total) && (rd_slot.task_id == r_item.task_id);
    assign proc_live = (r_idx < r_run) && (r_nres < CountBits'(MaxResults));
    assign proc_drop = proc_live && rd_slot.due && (rd_slot.mode <= MODE_REPEAT)
                       && (rd_slot.remaining == '0);
    assign proc_fire = proc_live && rd_slot.due && !proc_drop;

    // The move of an entry is done as a ripple of single-slot copies from r_src
    // toward r_dst, after which the held entry is placed at r_dst.
    always_comb begin
        rd_idx = r_idx[SlotBits-1:0];
        if (r_state == ST_SHIFT) begin
            rd_idx = (r_src < r_dst) ? SlotBits'(r_src + 1'b1) : SlotBits'(r_src - 1'b1);
        end
    end

    always_comb begin
        wr_en = 1'b0;
        wr_idx = r_src[SlotBits-1:0];
        wr_slot = rd_slot;
        case (r_state)
            ST_SHIFT: begin
                wr_en = (r_src != r_dst);
            end
            ST_PLACE: begin
                wr_en = 1'b1;
                wr_idx = r_dst[SlotBits-1:0];
                wr_slot = r_hold;
            end
            ST_TICK: begin
                wr_en = (r_idx < r_run);
                wr_idx = r_idx[SlotBits-1:0];
                if (inc >= {1'b0, rd_slot.period}) begin
                    wr_slot.elapsed = '0;
                    wr_slot.due = 1'b1;
                end else begin
                    wr_slot.elapsed = inc[31:0];
                end
            end
            ST_PROC: begin
                wr_idx = r_idx[SlotBits-1:0];
                if (proc_fire) begin
                    wr_en = 1'b1;
                    wr_slot.due = (rd_slot.mode == MODE_ONESHOT);
                    if (rd_slot.mode <= MODE_REPEAT) begin
                        wr_slot.remaining = rd_slot.remaining - 16'd1;
                    end
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Entry written by a register operation.
    always_comb begin
        reg_slot.task_id = r_item.task_id;
        reg_slot.mode = r_item.run_mode;
        reg_slot.elapsed = '0;
        if (one_shot) begin
            reg_slot.period = (r_item.period_ticks == '0) ? 32'd1 : r_item.period_ticks;
            reg_slot.remaining = 16'd1;
            reg_slot.due = 1'b0;
        end else begin
            reg_slot.period = r_item.period_ticks;
            reg_slot.remaining = r_item.repeat_count;
            // A task already in the table keeps its due bit.
            reg_slot.due = r_hit & r_hold.due;
        end
    end

    always_comb begin
        case (r_item.opcode)
            OP_REGISTER: move_needed = !full;
            OP_REMOVE:   move_needed = r_hit;
            OP_SUSPEND:  move_needed = r_hit && (r_found < r_run);
            OP_WAKE:     move_needed = r_hit && (r_found >= r_run);
            default:     move_needed = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_item.opcode)
                        OP_TICK:    n_state = ST_TICK;
                        OP_PROCESS: n_state = ST_PROC;
                        default:    n_state = ST_FIND;
                    endcase
                end
            end
            ST_FIND: begin
                if (find_hit || r_idx >= total) n_state = ST_DECIDE;
            end
            ST_DECIDE: n_state = move_needed ? ST_SHIFT : ST_EMIT;
            ST_SHIFT: begin
                if (r_src == r_dst) n_state = ST_PLACE;
            end
            ST_PLACE: n_state = (r_item.opcode == OP_PROCESS) ? ST_PROC : ST_EMIT;
            ST_TICK: begin
                if (r_idx >= r_run) n_state = ST_EMIT;
            end
            ST_PROC: begin
                if (!proc_live) n_state = ST_EMIT;
                else if (proc_drop) n_state = ST_SHIFT;
            end
            ST_EMIT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Result path: the final result of an item is built in r_pend. During a
    // process scan r_pend holds the latest dispatch, which goes out with last
    // clear once another dispatch is found, or with last set at the end.
    always_comb begin
        n_strobe = 1'b0;
        n_res = r_res;
        n_pend = r_pend;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_item.opcode == OP_PROCESS) begin
                        n_pend = '{kind: KIND_NONE_DUE, refused: 1'b0, task_out: 8'd0,
                                   task_state: TS_ABSENT, wants_verdict: 1'b0, last: 1'b1};
                    end else begin
                        n_pend = '{kind: KIND_ACK, refused: 1'b0, task_out: i_item.task_id,
                                   task_state: TS_ABSENT, wants_verdict: 1'b0, last: 1'b1};
                    end
                end
            end
            ST_DECIDE: begin
                if (r_item.opcode == OP_QUERY) begin
                    n_pend.kind = KIND_QUERY;
                    n_pend.task_state = !r_hit ? TS_ABSENT :
                        ((r_found < r_run) ? TS_RUNNING : TS_SUSPENDED);
                end else if (r_item.opcode == OP_REGISTER && full) begin
                    n_pend.refused = 1'b1;
                end
            end
            ST_PROC: begin
                if (proc_fire) begin
                    n_strobe = (r_nres != '0);
                    n_res = r_pend;
                    n_res.last = 1'b0;
                    n_pend = '{kind: KIND_DISPATCH, refused: 1'b0, task_out: rd_slot.task_id,
                               task_state: TS_ABSENT,
                               wants_verdict: (rd_slot.mode == MODE_VERDICT), last: 1'b1};
                end
            end
            ST_EMIT: begin
                n_strobe = 1'b1;
                n_res = r_pend;
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_run <= '0;
            r_susp <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_strobe <= n_strobe;
            r_res <= n_res;
            r_pend <= n_pend;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_item <= i_item;
                        r_idx <= '0;
                        r_hit <= 1'b0;
                        r_nres <= '0;
                    end
                end
                ST_FIND: begin
                    if (find_hit) begin
                        r_hit <= 1'b1;
                        r_found <= r_idx;
                        r_hold <= rd_slot;
                    end else if (r_idx < total) begin
                        r_idx <= r_idx + CountBits'(1);
                    end
                end
                ST_DECIDE: begin
                    case (r_item.opcode)
                        OP_REGISTER: begin
                            if (!full) begin
                                r_hold <= reg_slot;
                                if (!r_hit) begin
                                    r_src <= total;
                                    r_dst <= r_run;
                                    r_run <= r_run + CountBits'(1);
                                end else if (r_found >= r_run) begin
                                    r_src <= r_found;
                                    r_dst <= r_run;
                                    r_run <= r_run + CountBits'(1);
                                    r_susp <= r_susp - CountBits'(1);
                                end else begin
                                    r_src <= r_found;
                                    r_dst <= r_found;
                                end
                            end
                        end
                        OP_REMOVE: begin
                            if (r_hit) begin
                                r_src <= r_found;
                                r_dst <= total - CountBits'(1);
                                if (r_found < r_run) r_run <= r_run - CountBits'(1);
                                else r_susp <= r_susp - CountBits'(1);
                            end
                        end
                        OP_SUSPEND: begin
                            if (r_hit && r_found < r_run) begin
                                r_src <= r_found;
                                r_dst <= r_run - CountBits'(1);
                                r_run <= r_run - CountBits'(1);
                                r_susp <= r_susp + CountBits'(1);
                            end
                        end
                        OP_WAKE: begin
                            if (r_hit && r_found >= r_run) begin
                                r_src <= r_found;
                                r_dst <= r_run;
                                r_run <= r_run + CountBits'(1);
                                r_susp <= r_susp - CountBits'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                ST_SHIFT: begin
                    // Copy the neighbor into r_src, stepping toward r_dst.
                    if (r_src < r_dst) begin
                        r_src <= r_src + CountBits'(1);
                    end else if (r_src > r_dst) begin
                        r_src <= r_src - CountBits'(1);
                    end
                end
                ST_TICK: begin
                    if (r_idx < r_run) r_idx <= r_idx + CountBits'(1);
                end
                ST_PROC: begin
                    // A spent task is moved past the end of the table; the entry
                    // that slides into its slot is visited next.
                    if (proc_drop) begin
                        r_hold <= rd_slot;
                        r_src <= r_idx;
                        r_dst <= total - CountBits'(1);
                        r_run <= r_run - CountBits'(1);
                    end else if (proc_live) begin
                        r_idx <= r_idx + CountBits'(1);
                        if (proc_fire) r_nres <= r_nres + CountBits'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

// ===== tb/ptdt_checker.sv =====
// Checker for the periodic task dispatch table: mirrors the task table and compares every result.
module ptdt_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  ptdt_pkg::t_in_item   i_item,
    input  logic                 i_strobe,
    input  ptdt_pkg::t_out_item  i_result,
    output int                   o_errors,
    output int                   o_pending
);
    import ptdt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    t_slot     table_q [TableSlots];
    int        run_cnt;
    int        sus_cnt;
    t_out_item due_results[$];

    assign o_pending = due_results.size();

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        o_errors++;
    endtask

    function automatic void move_slot(int from, int to);
        t_slot s;
        s = table_q[from];
        if (from < to) begin
            for (int k = from; k < to; k++) table_q[k] = table_q[k + 1];
        end else begin
            for (int k = from; k > to; k--) table_q[k] = table_q[k - 1];
        end
        table_q[to] = s;
    endfunction

    function automatic int locate(int lo, int hi, logic [7:0] id);
        for (int k = lo; k < hi; k++)
            if (table_q[k].task_id == id) return k;
        return -1;
    endfunction

    function automatic void drop_slot(int p);
        move_slot(p, run_cnt + sus_cnt - 1);
        if (p < run_cnt) run_cnt--;
        else sus_cnt--;
    endfunction

    function automatic void push(logic [1:0] kind, logic refd, logic [7:0] tid,
                                 logic [1:0] st, logic verd);
        t_out_item r;
        r = '{kind: kind, refused: refd, task_out: tid, task_state: st,
              wants_verdict: verd, last: 1'b0};
        due_results.push_back(r);
    endfunction

    function automatic void predict_item(t_in_item it);
        int total, p, i, n;
        logic [15:0] cnt;
        logic [31:0] per;
        logic [32:0] e;
        total = run_cnt + sus_cnt;
        n = 0;
        cnt = it.repeat_count;
        per = it.period_ticks;
        case (it.opcode)
            OP_REGISTER: begin
                if (total >= TableSlots) begin
                    push(KIND_ACK, 1'b1, it.task_id, TS_ABSENT, 1'b0);
                end else begin
                    p = locate(0, total, it.task_id);
                    if (p < 0) begin
                        table_q[total].due = 1'b0;
                        move_slot(total, run_cnt);
                        p = run_cnt;
                        run_cnt++;
                    end else if (p >= run_cnt) begin
                        move_slot(p, run_cnt);
                        p = run_cnt;
                        run_cnt++;
                        sus_cnt--;
                    end
                    table_q[p].task_id = it.task_id;
                    table_q[p].mode = it.run_mode;
                    if (it.run_mode == MODE_ONESHOT) begin
                        if (per == 0) per = 1;
                        cnt = 1;
                        table_q[p].due = 1'b0;
                    end
                    table_q[p].remaining = cnt;
                    table_q[p].period = per;
                    table_q[p].elapsed = '0;
                    push(KIND_ACK, 1'b0, it.task_id, TS_ABSENT, 1'b0);
                end
            end
            OP_REMOVE: begin
                p = locate(0, total, it.task_id);
                if (p >= 0) drop_slot(p);
                push(KIND_ACK, 1'b0, it.task_id, TS_ABSENT, 1'b0);
            end
            OP_SUSPEND: begin
                p = locate(0, run_cnt, it.task_id);
                if (p >= 0) begin
                    move_slot(p, run_cnt - 1);
                    run_cnt--;
                    sus_cnt++;
                end
                push(KIND_ACK, 1'b0, it.task_id, TS_ABSENT, 1'b0);
            end
            OP_WAKE: begin
                p = locate(run_cnt, total, it.task_id);
                if (p >= 0) begin
                    move_slot(p, run_cnt);
                    run_cnt++;
                    sus_cnt--;
                end
                push(KIND_ACK, 1'b0, it.task_id, TS_ABSENT, 1'b0);
            end
            OP_QUERY: begin
                p = locate(0, total, it.task_id);
                push(KIND_QUERY, 1'b0, it.task_id,
                     p < 0 ? TS_ABSENT : (p < run_cnt ? TS_RUNNING : TS_SUSPENDED), 1'b0);
            end
            OP_TICK: begin
                for (i = 0; i < run_cnt; i++) begin
                    e = {1'b0, table_q[i].elapsed} + 33'd1;
                    if (e >= {1'b0, table_q[i].period}) begin
                        table_q[i].elapsed = '0;
                        table_q[i].due = 1'b1;
                    end else begin
                        table_q[i].elapsed = e[31:0];
                    end
                end
                push(KIND_ACK, 1'b0, it.task_id, TS_ABSENT, 1'b0);
            end
            OP_PROCESS: begin
                i = 0;
                while (i < run_cnt && n < MaxResults) begin
                    if (table_q[i].due) begin
                        table_q[i].due = 1'b0;
                        if (table_q[i].mode == MODE_ONESHOT || table_q[i].mode == MODE_REPEAT)
                        begin
                            if (table_q[i].mode == MODE_ONESHOT) table_q[i].due = 1'b1;
                            if (table_q[i].remaining == 0) begin
                                drop_slot(i);
                                continue;
                            end
                            table_q[i].remaining--;
                            push(KIND_DISPATCH, 1'b0, table_q[i].task_id, TS_ABSENT, 1'b0);
                        end else begin
                            push(KIND_DISPATCH, 1'b0, table_q[i].task_id, TS_ABSENT,
                                 table_q[i].mode == MODE_VERDICT);
                        end
                        n++;
                    end
                    i++;
                end
                if (n == 0) push(KIND_NONE_DUE, 1'b0, 8'd0, TS_ABSENT, 1'b0);
            end
            default: push(KIND_ACK, 1'b0, it.task_id, TS_ABSENT, 1'b0);
        endcase
        due_results[$].last = 1'b1;
    endfunction

    initial begin
        o_errors = 0;
        run_cnt = 0;
        sus_cnt = 0;
        foreach (table_q[k]) table_q[k] = '0;
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n) begin
            // Results of an item never appear in its own accept cycle, so checking first is safe.
            if (i_strobe) begin
                if (due_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    exp_r = due_results.pop_front();
                    if (i_result.kind !== exp_r.kind)
                        report_mismatch($sformatf("kind %0d want %0d", i_result.kind, exp_r.kind));
                    if (i_result.refused !== exp_r.refused)
                        report_mismatch($sformatf("refused %0b want %0b",
                                                  i_result.refused, exp_r.refused));
                    if (i_result.task_out !== exp_r.task_out)
                        report_mismatch($sformatf("task_out %0d want %0d",
                                                  i_result.task_out, exp_r.task_out));
                    if (i_result.task_state !== exp_r.task_state)
                        report_mismatch($sformatf("task_state %0d want %0d",
                                                  i_result.task_state, exp_r.task_state));
                    if (i_result.wants_verdict !== exp_r.wants_verdict)
                        report_mismatch($sformatf("wants_verdict %0b want %0b",
                                                  i_result.wants_verdict, exp_r.wants_verdict));
                    if (i_result.last !== exp_r.last)
                        report_mismatch($sformatf("last %0b want %0b",
                                                  i_result.last, exp_r.last));
                end
            end
            if (i_start && !i_busy) predict_item(i_item);
        end
    end
endmodule

// ===== tb/periodic_task_dispatch_table_tb.sv =====
// Testbench top for the periodic task dispatch table: stimulus, clock, reset and verdict.
module periodic_task_dispatch_table_tb;
    import ptdt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_item  item = '0;
    logic      busy;
    logic      strobe;
    t_out_item result;
    int        errors;
    int        pending;
    int        idle_pct = 30;
    logic [7:0] id_pool [6] = '{8'd0, 8'd255, 8'd17, 8'd42, 8'd128, 8'd7};

    always #4 i_clk = ~i_clk;

    periodic_task_dispatch_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(item),
        .busy(busy), .o_strobe(strobe), .o_result(result)
    );

    ptdt_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_item(item), .i_strobe(strobe), .i_result(result),
        .o_errors(errors), .o_pending(pending)
    );

    // Present one item and hold start until the block takes it. Start stays high
    // afterwards so that the next item can follow without a gap.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        item <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // Stop sending and wait until every expected result has come.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(logic [2:0] op, logic [7:0] id, logic [1:0] md,
                                           logic [15:0] cnt, logic [31:0] per);
        t_in_item it;
        it = '{opcode: op, task_id: id, run_mode: md, repeat_count: cnt, period_ticks: per};
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        logic [63:0] raw;
        int r;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        r = $urandom_range(99);
        // Mostly a small id pool so tasks get hit repeatedly; small periods so they fall due.
        if ($urandom_range(9) < 8) it.task_id = id_pool[$urandom_range(5)];
        if ($urandom_range(9) < 8) it.period_ticks = $urandom_range(3);
        if ($urandom_range(9) < 7) it.repeat_count = 16'($urandom_range(4));
        if (r < 25) it.opcode = OP_REGISTER;
        else if (r < 50) it.opcode = OP_TICK;
        else if (r < 72) it.opcode = OP_PROCESS;
        else if (r < 80) it.opcode = OP_QUERY;
        else if (r < 86) it.opcode = OP_SUSPEND;
        else if (r < 92) it.opcode = OP_WAKE;
        else if (r < 97) it.opcode = OP_REMOVE;
        else it.opcode = OP_SPARE;
        return it;
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_pct = 0;
        // Directed: every opcode, the field extremes, and the special cases.
        send_item(make_item(OP_PROCESS, 8'd0, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_REGISTER, 8'd0, MODE_ONESHOT, 16'hFFFF, 32'd0));
        send_item(make_item(OP_REGISTER, 8'd255, MODE_REPEAT, 16'd0, 32'd0));
        send_item(make_item(OP_REGISTER, 8'd1, MODE_REPEAT, 16'd2, 32'd1));
        send_item(make_item(OP_REGISTER, 8'd2, MODE_FOREVER, 16'hFFFF, 32'hFFFFFFFF));
        send_item(make_item(OP_REGISTER, 8'd3, MODE_VERDICT, 16'd5, 32'd0));
        send_item(make_item(OP_SUSPEND, 8'd2, 2'd3, 16'hFFFF, 32'hFFFFFFFF));
        send_item(make_item(OP_QUERY, 8'd2, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_QUERY, 8'd99, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_TICK, 8'd77, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_PROCESS, 8'd0, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_TICK, 8'd0, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_PROCESS, 8'd0, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_WAKE, 8'd2, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_WAKE, 8'd50, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_REMOVE, 8'd3, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_REMOVE, 8'd60, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_SUSPEND, 8'd61, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_SPARE, 8'd9, 2'd0, 16'd0, 32'd0));
        // Fill the table past capacity to see refusals, then let many fall due.
        for (int k = 0; k < 18; k++)
            send_item(make_item(OP_REGISTER, 8'd100 + k[7:0], MODE_VERDICT, 16'd1, 32'd0));
        send_item(make_item(OP_REGISTER, 8'd1, MODE_REPEAT, 16'd3, 32'd0));
        send_item(make_item(OP_TICK, 8'd0, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_PROCESS, 8'd0, 2'd0, 16'd0, 32'd0));
        send_item(make_item(OP_PROCESS, 8'd0, 2'd0, 16'd0, 32'd0));
        drain();
        for (int k = 0; k < 18; k++)
            send_item(make_item(OP_REMOVE, 8'd100 + k[7:0], 2'd0, 16'd0, 32'd0));
        idle_pct = 30;
        for (int k = 0; k < 110; k++) begin
            idle_pct = (k >= 40 && k < 75) ? 0 : 30;
            if (k == 80) drain();
            send_item(random_item());
        end
        drain();
        repeat (60) @(posedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
